// ===== sv/bur_pkg.sv =====
// bur_pkg: widths, codes and helper functions for the 3x3 basis unscale and repair unit
// depends on nothing; used by sv/basis_unscale_repair_3x3_unit.sv

package bur_pkg;

    // default width of the signed Q16.16 matrix inputs
    localparam int DATA_WIDTH_DEF = 32;

    // width of a column after repair; holds inputs and cross products alike
    localparam int XW = 62;
    // width of the bit position of a column magnitude
    localparam int PW = 6;
    // block-scaled component, signed; magnitudes lie below 2^SCALE_TOP+1
    localparam int SW = 31;
    localparam int MW = SW - 1;
    localparam int SCALE_TOP = 29;
    // cross product terms
    localparam int PRW = 2 * SW;
    // squared magnitude of one component and the square-root working width
    localparam int SQW = 2 * MW;
    localparam int RW = 62;
    localparam int ROOT_STEPS = 31;
    // column length and divisor
    localparam int LW = 31;
    localparam int DVW = LW + 1;
    // quotient bits and dividend width
    localparam int QW = 17;
    localparam int NW = 48;
    // output width, signed Q1.16
    localparam int OW = 18;
    // components below this bit count may still form a zero column
    localparam int SMALL_BITS = 16;
    localparam int ZSW = 2 * SMALL_BITS + 2;

    localparam logic signed [XW-1:0] UNIT_ONE = XW'(65536);

    typedef logic signed [XW-1:0] comp_t;

    // column that the cross product rebuilds
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_C0,
        SEL_C1,
        SEL_C2
    } sel_t;

    // magnitude of a column component
    function automatic logic [XW-1:0] mag_f(input logic signed [XW-1:0] v);
        return v[XW-1] ? XW'(-v) : XW'(v);
    endfunction

    // largest of three magnitudes
    function automatic logic [XW-1:0] max3_f(input logic [XW-1:0] a,
                                             input logic [XW-1:0] b,
                                             input logic [XW-1:0] c);
        logic [XW-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // position of the leading one, zero for a zero word
    function automatic logic [PW-1:0] lead_pos_f(input logic [XW-1:0] m);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < XW; i++) begin
            if (m[i]) begin
                p = PW'(i);
            end
        end
        return p;
    endfunction

    // shift a magnitude so that a leading one at p lands on SCALE_TOP
    function automatic logic [MW-1:0] scale_mag_f(input logic [XW-1:0] a,
                                                  input logic [PW-1:0] p);
        logic [XW-1:0] s;
        if (p >= PW'(SCALE_TOP)) begin
            s = a >> (p - PW'(SCALE_TOP));
        end else begin
            s = a << (PW'(SCALE_TOP) - p);
        end
        return s[MW-1:0];
    endfunction

    // signed block-scaled component, shift on the magnitude
    function automatic logic signed [SW-1:0] scale_f(input logic signed [XW-1:0] v,
                                                     input logic [PW-1:0] p);
        logic [MW-1:0] m;
        m = scale_mag_f(mag_f(v), p);
        return v[XW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

// ===== sv/basis_unscale_repair_3x3_unit.sv =====
// basis_unscale_repair_3x3_unit: removes the scale of a 3x3 basis, rebuilds zero columns
// depends on bur_pkg (sv/bur_pkg.sv)

// Takes one signed Q16.16 3x3 matrix per request and returns its unit basis in
// signed Q1.16, one result per request. The unit is a 63-stage pipeline: a new
// matrix can enter every cycle unless a result waiting at the output is not taken.
// Among its stages are the 31 bit-pair stages of the column-length square root
// and the 17 quotient stages of the divider that scales each component. Columns
// whose squared length lies below the threshold (written through the cfg channel,
// reset value 1) are rebuilt from the others, or set to the identity when all
// three are zero; a column that is still zero after that gives zeros and raises
// degenerate_flag. Write the threshold only while no request is in flight.

module basis_unscale_repair_3x3_unit #(
    parameter int DATA_WIDTH = bur_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [31:0]                   cfg_data,
    // matrix requests
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [DATA_WIDTH-1:0]  m00,
    input  logic signed [DATA_WIDTH-1:0]  m01,
    input  logic signed [DATA_WIDTH-1:0]  m02,
    input  logic signed [DATA_WIDTH-1:0]  m10,
    input  logic signed [DATA_WIDTH-1:0]  m11,
    input  logic signed [DATA_WIDTH-1:0]  m12,
    input  logic signed [DATA_WIDTH-1:0]  m20,
    input  logic signed [DATA_WIDTH-1:0]  m21,
    input  logic signed [DATA_WIDTH-1:0]  m22,
    // unit basis results
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [bur_pkg::OW-1:0] u00,
    output logic signed [bur_pkg::OW-1:0] u01,
    output logic signed [bur_pkg::OW-1:0] u02,
    output logic signed [bur_pkg::OW-1:0] u10,
    output logic signed [bur_pkg::OW-1:0] u11,
    output logic signed [bur_pkg::OW-1:0] u12,
    output logic signed [bur_pkg::OW-1:0] u20,
    output logic signed [bur_pkg::OW-1:0] u21,
    output logic signed [bur_pkg::OW-1:0] u22,
    output logic                          degenerate_flag
);

    localparam int XW    = bur_pkg::XW;
    localparam int PW    = bur_pkg::PW;
    localparam int SW    = bur_pkg::SW;
    localparam int MW    = bur_pkg::MW;
    localparam int PRW   = bur_pkg::PRW;
    localparam int SQW   = bur_pkg::SQW;
    localparam int RW    = bur_pkg::RW;
    localparam int RS    = bur_pkg::ROOT_STEPS;
    localparam int LW    = bur_pkg::LW;
    localparam int DVW   = bur_pkg::DVW;
    localparam int QW    = bur_pkg::QW;
    localparam int NW    = bur_pkg::NW;
    localparam int OW    = bur_pkg::OW;
    localparam int SB    = bur_pkg::SMALL_BITS;
    localparam int ZSW   = bur_pkg::ZSW;
    localparam int NST   = 15 + RS + QW;

    // pipeline control: every stage moves when the output stage is free
    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv       = !vld_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NST-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // threshold register
    logic [31:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 32'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // stage 1: input registers, indexed [column][row]
    logic signed [DATA_WIDTH-1:0] s1_m_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_m_reg[0][0] <= m00;
            s1_m_reg[1][0] <= m01;
            s1_m_reg[2][0] <= m02;
            s1_m_reg[0][1] <= m10;
            s1_m_reg[1][1] <= m11;
            s1_m_reg[2][1] <= m12;
            s1_m_reg[0][2] <= m20;
            s1_m_reg[1][2] <= m21;
            s1_m_reg[2][2] <= m22;
        end
    end

    // stage 2: zero-column test
    bur_pkg::comp_t  s1_ext [3][3];
    logic [XW-1:0]   s1_mag [3][3];
    logic [2*SB-1:0] s1_a16 [3][3];
    logic [ZSW-1:0]  s1_sum [3];
    logic [2:0]      s1_small;
    logic [2:0]      zero_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            s1_sum[c]   = '0;
            s1_small[c] = 1'b1;
            for (int r = 0; r < 3; r++)
            begin
                s1_ext[c][r] = XW'(s1_m_reg[c][r]);
                s1_mag[c][r] = bur_pkg::mag_f(s1_ext[c][r]);
                s1_a16[c][r] = (2*SB)'(s1_mag[c][r][SB-1:0]);
                if (s1_mag[c][r][XW-1:SB] != '0)
                begin
                    s1_small[c] = 1'b0;
                end
                s1_sum[c] = s1_sum[c] + ZSW'(s1_a16[c][r] * s1_a16[c][r]);
            end
            zero_next[c] = s1_small[c] && (s1_sum[c] < ZSW'(thr_reg));
        end
    end

    bur_pkg::comp_t s2_col_reg [3][3];
    logic [2:0]     s2_zero_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_col_reg  <= s1_ext;
            s2_zero_reg <= zero_next;
        end
    end

    // stage 3: case table repair, pick cross operands
    bur_pkg::comp_t rp_col [3][3];
    bur_pkg::comp_t rp_p [3];
    bur_pkg::comp_t rp_q [3];
    bur_pkg::sel_t  rp_sel;

    always_comb
    begin
        rp_col = s2_col_reg;
        rp_p   = '{default: '0};
        rp_q   = '{default: '0};
        rp_sel = bur_pkg::SEL_NONE;
        priority if (s2_zero_reg == 3'b111)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    rp_col[c][r] = (c == r) ? bur_pkg::UNIT_ONE : '0;
                end
            end
        end
        else if (s2_zero_reg[0] && s2_zero_reg[1])
        begin
            rp_col[1][0] = '0;
            rp_col[1][1] = s2_col_reg[2][2];
            rp_col[1][2] = -s2_col_reg[2][1];
            rp_p   = rp_col[1];
            rp_q   = s2_col_reg[2];
            rp_sel = bur_pkg::SEL_C0;
        end
        else if (s2_zero_reg[0] && s2_zero_reg[2])
        begin
            rp_col[0][0] = s2_col_reg[1][1];
            rp_col[0][1] = -s2_col_reg[1][0];
            rp_col[0][2] = '0;
            rp_p   = rp_col[0];
            rp_q   = s2_col_reg[1];
            rp_sel = bur_pkg::SEL_C2;
        end
        else if (s2_zero_reg[0])
        begin
            rp_p   = s2_col_reg[1];
            rp_q   = s2_col_reg[2];
            rp_sel = bur_pkg::SEL_C0;
        end
        else if (s2_zero_reg[1] && s2_zero_reg[2])
        begin
            rp_col[2][0] = -s2_col_reg[0][2];
            rp_col[2][1] = '0;
            rp_col[2][2] = s2_col_reg[0][0];
            rp_p   = rp_col[2];
            rp_q   = s2_col_reg[0];
            rp_sel = bur_pkg::SEL_C1;
        end
        else if (s2_zero_reg[1])
        begin
            rp_p   = s2_col_reg[2];
            rp_q   = s2_col_reg[0];
            rp_sel = bur_pkg::SEL_C1;
        end
        else if (s2_zero_reg[2])
        begin
            rp_p   = s2_col_reg[0];
            rp_q   = s2_col_reg[1];
            rp_sel = bur_pkg::SEL_C2;
        end
        else
        begin
            rp_sel = bur_pkg::SEL_NONE;
        end
    end

    bur_pkg::comp_t s3_col_reg [3][3];
    bur_pkg::comp_t s3_p_reg [3];
    bur_pkg::comp_t s3_q_reg [3];
    bur_pkg::sel_t  s3_sel_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_col_reg <= rp_col;
            s3_p_reg   <= rp_p;
            s3_q_reg   <= rp_q;
            s3_sel_reg <= rp_sel;
        end
    end

    // stage 4: largest operand magnitudes
    bur_pkg::comp_t s4_col_reg [3][3];
    bur_pkg::comp_t s4_p_reg [3];
    bur_pkg::comp_t s4_q_reg [3];
    bur_pkg::sel_t  s4_sel_reg;
    logic [XW-1:0]  s4_pmax_reg;
    logic [XW-1:0]  s4_qmax_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_col_reg  <= s3_col_reg;
            s4_p_reg    <= s3_p_reg;
            s4_q_reg    <= s3_q_reg;
            s4_sel_reg  <= s3_sel_reg;
            s4_pmax_reg <= bur_pkg::max3_f(bur_pkg::mag_f(s3_p_reg[0]),
                                           bur_pkg::mag_f(s3_p_reg[1]),
                                           bur_pkg::mag_f(s3_p_reg[2]));
            s4_qmax_reg <= bur_pkg::max3_f(bur_pkg::mag_f(s3_q_reg[0]),
                                           bur_pkg::mag_f(s3_q_reg[1]),
                                           bur_pkg::mag_f(s3_q_reg[2]));
        end
    end

    // stage 5: leading-one positions of the operands
    bur_pkg::comp_t s5_col_reg [3][3];
    bur_pkg::comp_t s5_p_reg [3];
    bur_pkg::comp_t s5_q_reg [3];
    bur_pkg::sel_t  s5_sel_reg;
    logic [PW-1:0]  s5_ppos_reg;
    logic [PW-1:0]  s5_qpos_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_col_reg  <= s4_col_reg;
            s5_p_reg    <= s4_p_reg;
            s5_q_reg    <= s4_q_reg;
            s5_sel_reg  <= s4_sel_reg;
            s5_ppos_reg <= bur_pkg::lead_pos_f(s4_pmax_reg);
            s5_qpos_reg <= bur_pkg::lead_pos_f(s4_qmax_reg);
        end
    end

    // stage 6: block-scaled cross operands
    bur_pkg::comp_t          s6_col_reg [3][3];
    bur_pkg::sel_t           s6_sel_reg;
    logic signed [SW-1:0]    s6_a_reg [3];
    logic signed [SW-1:0]    s6_b_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_col_reg <= s5_col_reg;
            s6_sel_reg <= s5_sel_reg;
            for (int i = 0; i < 3; i++)
            begin
                s6_a_reg[i] <= bur_pkg::scale_f(s5_p_reg[i], s5_ppos_reg);
                s6_b_reg[i] <= bur_pkg::scale_f(s5_q_reg[i], s5_qpos_reg);
            end
        end
    end

    // stage 7: cross product terms
    bur_pkg::comp_t        s7_col_reg [3][3];
    bur_pkg::sel_t         s7_sel_reg;
    logic signed [PRW-1:0] s7_pr_reg [6];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_col_reg   <= s6_col_reg;
            s7_sel_reg   <= s6_sel_reg;
            s7_pr_reg[0] <= PRW'(s6_a_reg[1]) * PRW'(s6_b_reg[2]);
            s7_pr_reg[1] <= PRW'(s6_a_reg[2]) * PRW'(s6_b_reg[1]);
            s7_pr_reg[2] <= PRW'(s6_a_reg[2]) * PRW'(s6_b_reg[0]);
            s7_pr_reg[3] <= PRW'(s6_a_reg[0]) * PRW'(s6_b_reg[2]);
            s7_pr_reg[4] <= PRW'(s6_a_reg[0]) * PRW'(s6_b_reg[1]);
            s7_pr_reg[5] <= PRW'(s6_a_reg[1]) * PRW'(s6_b_reg[0]);
        end
    end

    // stage 8: cross product replaces the rebuilt column
    bur_pkg::comp_t cr_vec [3];
    bur_pkg::comp_t s8_col_next [3][3];

    always_comb
    begin
        cr_vec[0]   = XW'(s7_pr_reg[0] - s7_pr_reg[1]);
        cr_vec[1]   = XW'(s7_pr_reg[2] - s7_pr_reg[3]);
        cr_vec[2]   = XW'(s7_pr_reg[4] - s7_pr_reg[5]);
        s8_col_next = s7_col_reg;
        unique case (s7_sel_reg)
            bur_pkg::SEL_C0:   s8_col_next[0] = cr_vec;
            bur_pkg::SEL_C1:   s8_col_next[1] = cr_vec;
            bur_pkg::SEL_C2:   s8_col_next[2] = cr_vec;
            bur_pkg::SEL_NONE: s8_col_next    = s7_col_reg;
            default:           s8_col_next    = s7_col_reg;
        endcase
    end

    bur_pkg::comp_t s8_col_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_col_reg <= s8_col_next;
        end
    end

    // normalize stage 1: largest magnitude per column
    bur_pkg::comp_t u1_col_reg [3][3];
    logic [XW-1:0]  u1_max_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_col_reg <= s8_col_reg;
            for (int c = 0; c < 3; c++)
            begin
                u1_max_reg[c] <= bur_pkg::max3_f(bur_pkg::mag_f(s8_col_reg[c][0]),
                                                 bur_pkg::mag_f(s8_col_reg[c][1]),
                                                 bur_pkg::mag_f(s8_col_reg[c][2]));
            end
        end
    end

    // normalize stage 2: leading-one position, zero column mark
    bur_pkg::comp_t u2_col_reg [3][3];
    logic [PW-1:0]  u2_pos_reg [3];
    logic [2:0]     u2_nz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u2_col_reg <= u1_col_reg;
            for (int c = 0; c < 3; c++)
            begin
                u2_pos_reg[c] <= bur_pkg::lead_pos_f(u1_max_reg[c]);
                u2_nz_reg[c]  <= (u1_max_reg[c] != '0);
            end
        end
    end

    // normalize stage 3: block-scaled magnitudes and signs
    logic [MW-1:0] u3_mag_reg [3][3];
    logic [2:0]    u3_neg_reg [3];
    logic [2:0]    u3_nz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u3_nz_reg <= u2_nz_reg;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    u3_mag_reg[c][r] <= bur_pkg::scale_mag_f(bur_pkg::mag_f(u2_col_reg[c][r]),
                                                             u2_pos_reg[c]);
                    u3_neg_reg[c][r] <= u2_col_reg[c][r][XW-1];
                end
            end
        end
    end

    // normalize stage 4: squares
    logic [SQW-1:0] u4_sq_reg [3][3];
    logic [MW-1:0]  u4_mag_reg [3][3];
    logic [2:0]     u4_neg_reg [3];
    logic [2:0]     u4_nz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u4_mag_reg <= u3_mag_reg;
            u4_neg_reg <= u3_neg_reg;
            u4_nz_reg  <= u3_nz_reg;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    u4_sq_reg[c][r] <= SQW'(u3_mag_reg[c][r]) * SQW'(u3_mag_reg[c][r]);
                end
            end
        end
    end

    // square root pipeline, entry 0 holds the sum of squares
    logic [RW-1:0] rt_n_reg   [RS+1][3];
    logic [RW-1:0] rt_res_reg [RS+1][3];
    logic [MW-1:0] rt_mag_reg [RS+1][3][3];
    logic [2:0]    rt_neg_reg [RS+1][3];
    logic [2:0]    rt_nz_reg  [RS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_mag_reg[0] <= u4_mag_reg;
            rt_neg_reg[0] <= u4_neg_reg;
            rt_nz_reg[0]  <= u4_nz_reg;
            for (int c = 0; c < 3; c++)
            begin
                rt_n_reg[0][c]   <= RW'(u4_sq_reg[c][0]) + RW'(u4_sq_reg[c][1])
                                  + RW'(u4_sq_reg[c][2]);
                rt_res_reg[0][c] <= '0;
            end
        end
    end

    // one result bit per stage
    for (genvar k = 0; k < RS; k++)
    begin : g_root
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (RS - 1 - k));
        logic [RW-1:0] trial    [3];
        logic [RW-1:0] n_next   [3];
        logic [RW-1:0] res_next [3];

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                trial[c] = rt_res_reg[k][c] + BIT;
                if (rt_n_reg[k][c] >= trial[c])
                begin
                    n_next[c]   = rt_n_reg[k][c] - trial[c];
                    res_next[c] = (rt_res_reg[k][c] >> 1) + BIT;
                end
                else
                begin
                    n_next[c]   = rt_n_reg[k][c];
                    res_next[c] = rt_res_reg[k][c] >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_n_reg[k+1]   <= n_next;
                rt_res_reg[k+1] <= res_next;
                rt_mag_reg[k+1] <= rt_mag_reg[k];
                rt_neg_reg[k+1] <= rt_neg_reg[k];
                rt_nz_reg[k+1]  <= rt_nz_reg[k];
            end
        end
    end

    // divider pipeline, entry 0 holds dividend and divisor
    logic [NW-1:0]  dv_rem_reg [QW+1][3][3];
    logic [QW-1:0]  dv_q_reg   [QW+1][3][3];
    logic [DVW-1:0] dv_d_reg   [QW+1][3];
    logic [2:0]     dv_neg_reg [QW+1][3];
    logic [2:0]     dv_nz_reg  [QW+1];
    logic [LW-1:0]  rt_len [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rt_len[c] = rt_res_reg[RS][c][LW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_neg_reg[0] <= rt_neg_reg[RS];
            dv_nz_reg[0]  <= rt_nz_reg[RS];
            for (int c = 0; c < 3; c++)
            begin
                dv_d_reg[0][c] <= {rt_len[c], 1'b0};
                for (int r = 0; r < 3; r++)
                begin
                    dv_rem_reg[0][c][r] <= NW'({rt_mag_reg[RS][c][r], {QW{1'b0}}})
                                         + NW'(rt_len[c]);
                    dv_q_reg[0][c][r]   <= '0;
                end
            end
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int SH = QW - 1 - k;
        logic [NW-1:0] dd       [3];
        logic [NW-1:0] rem_next [3][3];
        logic [QW-1:0] q_next   [3][3];

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                dd[c] = NW'(dv_d_reg[k][c]) << SH;
                for (int r = 0; r < 3; r++)
                begin
                    if (dv_rem_reg[k][c][r] >= dd[c])
                    begin
                        rem_next[c][r] = dv_rem_reg[k][c][r] - dd[c];
                        q_next[c][r]   = dv_q_reg[k][c][r] | (QW'(1) << SH);
                    end
                    else
                    begin
                        rem_next[c][r] = dv_rem_reg[k][c][r];
                        q_next[c][r]   = dv_q_reg[k][c][r];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[k+1] <= rem_next;
                dv_q_reg[k+1]   <= q_next;
                dv_d_reg[k+1]   <= dv_d_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_nz_reg[k+1]  <= dv_nz_reg[k];
            end
        end
    end

    // output register: restore signs, zero the degenerate columns
    logic signed [OW-1:0] out_u_reg [3][3];
    logic                 out_deg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_deg_reg <= (dv_nz_reg[QW] != 3'b111);
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    if (!dv_nz_reg[QW][c])
                    begin
                        out_u_reg[c][r] <= '0;
                    end
                    else if (dv_neg_reg[QW][c][r])
                    begin
                        out_u_reg[c][r] <= -$signed({1'b0, dv_q_reg[QW][c][r]});
                    end
                    else
                    begin
                        out_u_reg[c][r] <= $signed({1'b0, dv_q_reg[QW][c][r]});
                    end
                end
            end
        end
    end

    assign u00 = out_u_reg[0][0];
    assign u01 = out_u_reg[1][0];
    assign u02 = out_u_reg[2][0];
    assign u10 = out_u_reg[0][1];
    assign u11 = out_u_reg[1][1];
    assign u12 = out_u_reg[2][1];
    assign u20 = out_u_reg[0][2];
    assign u21 = out_u_reg[1][2];
    assign u22 = out_u_reg[2][2];
    assign degenerate_flag = out_deg_reg;

endmodule
